// ----- rtl/lhb_pkg.sv -----
// Shared types and constants for the label hash bucket block.
package lhb_pkg;

	localparam int unsigned HASH_W  = 32;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned SIZE_W  = 16;
	localparam int unsigned CNT_W   = $clog2(HASH_W);

	localparam logic [HASH_W-1:0] HASH_MULT = 32'h0000_0492;
	localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(HASH_W - 1);

	// Controller commands to the datapath
	typedef struct packed {
		logic hash_step;  // fold a nonzero byte into the hash
		logic div_start;  // load dividend from hash, clear hash
		logic div_step;   // one restoring divide step
		logic out_load;   // capture remainder (zero when the table size is zero) into the output register
	} lhb_cmd_t;

	// Datapath status to the controller
	typedef struct packed {
		logic byte_zero;  // current input byte ends the label
	} lhb_stat_t;

endpackage

// ----- rtl/lhb_dp.sv -----
// Datapath: running hash, table size register, bit-serial divider, output register.
module lhb_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lhb_pkg::lhb_cmd_t            cmd,
	output lhb_pkg::lhb_stat_t           stat,
	input  logic [lhb_pkg::BYTE_W-1:0]   char_code,
	input  logic                         cfg_wr,
	input  logic [lhb_pkg::SIZE_W-1:0]   cfg_data,
	output logic [lhb_pkg::SIZE_W-1:0]   bucket_index
);
	import lhb_pkg::*;

	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] dvd_q;
	logic [SIZE_W-1:0] rem_q;
	logic [SIZE_W-1:0] tsize_q;
	logic [SIZE_W-1:0] bucket_q;
	logic [SIZE_W:0]   trial;
	logic [SIZE_W:0]   diff;
	logic              fits;

	assign stat.byte_zero = (char_code == '0);

	// Restoring step: shift in next dividend bit, subtract when it fits
	assign trial = {rem_q, dvd_q[HASH_W-1]};
	assign diff  = trial - {1'b0, tsize_q};
	assign fits  = (trial >= {1'b0, tsize_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q  <= '0;
			tsize_q <= SIZE_W'(1);
		end else begin
			if (cfg_wr) begin
				tsize_q <= cfg_data;
			end
			if (cmd.div_start) begin
				hash_q <= '0;
			end else if (cmd.hash_step) begin
				hash_q <= hash_q * HASH_MULT + {{(HASH_W-BYTE_W){1'b0}}, char_code};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvd_q <= hash_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[HASH_W-2:0], 1'b0};
			rem_q <= fits ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
		end
		if (cmd.out_load) begin
			bucket_q <= (tsize_q == '0) ? '0 : rem_q;
		end
	end

	assign bucket_index = bucket_q;

endmodule

// ----- rtl/lhb_ctrl.sv -----
// Controller: input/output handshakes, divide sequencing and step count.
module lhb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  lhb_pkg::lhb_stat_t   stat,
	output lhb_pkg::lhb_cmd_t    cmd
);
	import lhb_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_LOAD = 3'b100
	} lhb_state_t;

	lhb_state_t       state_q;
	lhb_state_t       state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             in_acc;
	logic             out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d       = state_q;
		cmd.hash_step = 1'b0;
		cmd.div_start = 1'b0;
		cmd.div_step  = 1'b0;
		cmd.out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (stat.byte_zero) begin
						cmd.div_start = 1'b1;
						state_d       = ST_DIV;
					end else begin
						cmd.hash_step = 1'b1;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_LAST) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				// hold the remainder until the output register frees up
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_start_enters_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> (state_q == ST_DIV) && (cnt_q == '0))
		else $error("divide did not start from a zero step count");

	a_idle_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (cnt_q == '0))
		else $error("step count not cleared after divide");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !cmd.out_load)
		else $error("result loaded over a stalled result");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state lost its one-hot code");

endmodule

// ----- rtl/label_hash_bucket.sv -----
// Top level of the label hash bucket block: controller plus datapath.
//
//  channel | signals                       | direction | beat when
//  --------+-------------------------------+-----------+--------------------------
//  in      | in_valid, in_stall, char_code | into blk  | in_valid && !in_stall
//  out     | out_valid, out_stall,         | out of blk| out_valid && !out_stall
//          | bucket_index                  |           |
//  cfg     | cfg_valid, cfg_ready, cfg_data| into blk  | cfg_valid && cfg_ready
//
// A nonzero byte is folded into the hash by one constant multiply-add.
// A zero byte is accepted, runs 32 steps of the one-bit restoring divider and
// then loads the output register before the next beat is taken.
// A stalled result waits in the output register while new bytes keep folding
// into the hash; only the load of the next remainder waits on the stall.
// Reset (arst_n low) clears the hash, sets table_size to 1 and empties output.
module label_hash_bucket (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [lhb_pkg::BYTE_W-1:0]   char_code,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [lhb_pkg::SIZE_W-1:0]   bucket_index,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lhb_pkg::SIZE_W-1:0]   cfg_data
);
	import lhb_pkg::*;

	lhb_cmd_t  cmd;
	lhb_stat_t stat;

	// The table size register takes a write in any cycle
	assign cfg_ready = 1'b1;

	lhb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	lhb_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.char_code    (char_code),
		.cfg_wr       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.bucket_index (bucket_index)
	);

endmodule
